@@ design/ffcs_pkg.sv @@
package ffcs_pkg;

  localparam int CELL_W     = 2;
  localparam int RAND_W     = 16;
  localparam int THR_W      = 16;
  localparam int ROWS_W     = 12;
  localparam int COLS_W     = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam int MAX_COLS_DEF = 128;
  localparam int MAX_ROWS_DEF = 4095;
  localparam int ROWS_RESET   = 40;
  localparam int COLS_RESET   = 80;
  localparam int QUEUE_DEPTH  = 2;

  localparam int TREES_W = 4;
  localparam int GLIM_W  = THR_W + TREES_W;

  typedef logic [CELL_W-1:0] cell_t;

  localparam cell_t CELL_EMPTY = 2'd0;
  localparam cell_t CELL_TREE  = 2'd1;
  localparam cell_t CELL_FIRE  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IGN_THR  = 2'd0,
    CFG_GROW_THR = 2'd1,
    CFG_ROWS     = 2'd2,
    CFG_COLS     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [THR_W-1:0] ign_thr;
    logic [THR_W-1:0] grow_thr;
  } thr_t;

  // neighborhood bounds and position marks of the emitted cell
  typedef struct packed {
    logic has_top;
    logic has_bottom;
    logic has_left;
    logic has_right;
    logic eor;
    logic eof;
  } nb_t;

  typedef struct packed {
    cell_t             cur_cell;
    logic              emit;
    nb_t               nb;
    logic [RAND_W-1:0] ign;
    logic [RAND_W-1:0] grw;
  } item_t;

  typedef struct packed {
    cell_t upper;
    cell_t middle;
  } line_t;

endpackage

@@ design/ffcs_if.sv @@
interface ffcs_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  ffcs_pkg::cell_t             cell_in;
  logic [ffcs_pkg::RAND_W-1:0] ignite_rand;
  logic [ffcs_pkg::RAND_W-1:0] grow_rand;

  modport source (output valid, op, cell_in, ignite_rand, grow_rand, input ready);
  modport sink   (input valid, op, cell_in, ignite_rand, grow_rand, output ready);
endinterface

interface ffcs_out_if;
  logic            valid;
  logic            ready;
  ffcs_pkg::cell_t cell_out;
  logic            end_of_row;
  logic            end_of_frame;

  modport source (output valid, cell_out, end_of_row, end_of_frame, input ready);
  modport sink   (input valid, cell_out, end_of_row, end_of_frame, output ready);
endinterface

@@ design/ffcs_front.sv @@
module ffcs_front #(
  parameter int MAX_COLS = ffcs_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = ffcs_pkg::MAX_ROWS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [$clog2(MAX_COLS)-1:0]   last_col_i,
  input  logic [$clog2(MAX_ROWS+2)-1:0] last_row_i,
  ffcs_in_if.sink                       in_if,
  input  logic                          full_i,
  output logic                          push_o,
  output ffcs_pkg::item_t               item_o,
  output logic [$clog2(MAX_COLS)-1:0]   ic_o
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS + 2);

  logic [CW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic          primed;

  assign in_if.ready = !full_i;
  assign push_o      = in_if.valid && !full_i;
  assign ic_o        = in_col_q;

  always_comb begin
    primed = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && (in_col_q != '0));

    item_o.cur_cell = (in_if.op || (in_if.cell_in == 2'd3)) ? ffcs_pkg::CELL_EMPTY
                                                             : in_if.cell_in;
    item_o.emit          = primed;
    item_o.nb.has_top    = out_row_q != '0;
    item_o.nb.has_bottom = out_row_q < last_row_i;
    item_o.nb.has_left   = out_col_q != '0;
    item_o.nb.has_right  = out_col_q < last_col_i;
    item_o.nb.eor        = out_col_q >= last_col_i;
    item_o.nb.eof        = item_o.nb.eor && (out_row_q >= last_row_i);
    item_o.ign           = in_if.ignite_rand;
    item_o.grw           = in_if.grow_rand;

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (push_o) begin
      if (in_col_q >= last_col_i) begin
        in_col_d = '0;
        in_row_d = in_row_q + 1'b1;
      end else begin
        in_col_d = in_col_q + 1'b1;
      end
      if (primed) begin
        if (item_o.nb.eor) begin
          out_col_d = '0;
          out_row_d = out_row_q + 1'b1;
        end else begin
          out_col_d = out_col_q + 1'b1;
        end
        if (item_o.nb.eof) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  a_eof_restarts_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && item_o.emit && item_o.nb.eof |=>
      (in_col_q == '0) && (in_row_q == '0) && (out_col_q == '0) && (out_row_q == '0))
    else $error("frame counters not cleared after end of frame");

endmodule

@@ design/ffcs_queue.sv @@
module ffcs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ffcs_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]    count_q;

  assign full_o  = count_q == NW'(DEPTH);
  assign valid_o = count_q != '0;
  assign rdata_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NW'(DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

endmodule

@@ design/ffcs_back.sv @@
module ffcs_back #(
  parameter int MAX_COLS = ffcs_pkg::MAX_COLS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ffcs_pkg::thr_t              thr_i,
  input  logic                        q_valid_i,
  input  ffcs_pkg::item_t             q_item_i,
  input  logic [$clog2(MAX_COLS)-1:0] q_ic_i,
  output logic                        pop_o,
  ffcs_out_if.source                  out_if
);

  localparam int CW = $clog2(MAX_COLS);

  ffcs_pkg::line_t line_mem [MAX_COLS];
  ffcs_pkg::line_t rd_q, fwd_data_q, line_cur, wr_data;
  logic            fwd_q;

  logic            s1_valid_q;
  ffcs_pkg::item_t s1_item_q;
  logic [CW-1:0]   s1_ic_q;
  logic            s1_adv, out_free;

  ffcs_pkg::cell_t win_q [3][3];
  ffcs_pkg::cell_t win_d [3][3];

  logic [ffcs_pkg::TREES_W-1:0] trees, trees_p1;
  logic                         fire_near;
  logic [ffcs_pkg::GLIM_W-1:0]  grow_lim;
  ffcs_pkg::cell_t              centre, next_cell;

  logic            out_valid_q;
  ffcs_pkg::cell_t cell_q;
  logic            eor_q, eof_q;

  assign out_free = !out_valid_q || out_if.ready;
  assign s1_adv   = s1_valid_q && (!s1_item_q.emit || out_free);
  assign pop_o    = q_valid_i && (!s1_valid_q || s1_adv);

  assign line_cur       = fwd_q ? fwd_data_q : rd_q;
  assign wr_data.upper  = line_cur.middle;
  assign wr_data.middle = s1_item_q.cur_cell;

  // line store: read at pop, write back as the item leaves stage one
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      line_mem[s1_ic_q] <= wr_data;
    end
    if (pop_o) begin
      rd_q       <= line_mem[q_ic_i];
      fwd_data_q <= wr_data;
      s1_item_q  <= q_item_i;
      s1_ic_q    <= q_ic_i;
    end
  end

  always_comb begin
    win_d[0] = win_q[1];
    win_d[1] = win_q[2];
    win_d[2][0] = line_cur.upper;
    win_d[2][1] = line_cur.middle;
    win_d[2][2] = s1_item_q.cur_cell;
  end

  always_comb begin
    logic keep;
    trees     = '0;
    fire_near = 1'b0;
    for (int dc = 0; dc < 3; dc++) begin
      for (int dr = 0; dr < 3; dr++) begin
        keep = !((dc == 1) && (dr == 1))
            && !((dc == 0) && !s1_item_q.nb.has_left)
            && !((dc == 2) && !s1_item_q.nb.has_right)
            && !((dr == 0) && !s1_item_q.nb.has_top)
            && !((dr == 2) && !s1_item_q.nb.has_bottom);
        if (keep && (win_d[dc][dr] == ffcs_pkg::CELL_TREE)) begin
          trees = trees + 1'b1;
        end
        if (keep && (win_d[dc][dr] == ffcs_pkg::CELL_FIRE)) begin
          fire_near = 1'b1;
        end
      end
    end
    trees_p1 = trees + 1'b1;
    grow_lim = ffcs_pkg::GLIM_W'(thr_i.grow_thr) * ffcs_pkg::GLIM_W'(trees_p1);
    centre   = win_d[1][1];
    case (centre)
      ffcs_pkg::CELL_FIRE: begin
        next_cell = ffcs_pkg::CELL_EMPTY;
      end
      ffcs_pkg::CELL_TREE: begin
        next_cell = (fire_near || (s1_item_q.ign <= thr_i.ign_thr)) ? ffcs_pkg::CELL_FIRE
                                                                    : ffcs_pkg::CELL_TREE;
      end
      default: begin
        next_cell = (ffcs_pkg::GLIM_W'(s1_item_q.grw) <= grow_lim) ? ffcs_pkg::CELL_TREE
                                                                   : ffcs_pkg::CELL_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_item_q.emit) begin
      cell_q <= next_cell;
      eor_q  <= s1_item_q.nb.eor;
      eof_q  <= s1_item_q.nb.eof;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      win_q       <= '{default: ffcs_pkg::CELL_EMPTY};
    end else begin
      if (pop_o) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_adv && (s1_ic_q == q_ic_i);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        win_q <= win_d;
      end
      if (s1_adv && s1_item_q.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.cell_out     = cell_q;
  assign out_if.end_of_row   = eor_q;
  assign out_if.end_of_frame = eof_q;

  a_eof_is_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && eof_q |-> eor_q)
    else $error("end of frame without end of row");

endmodule

@@ design/forest_fire_cell_stencil_unit.sv @@
// Channel  Dir  Payload                                 Accepted when
// in_if    in   op, cell_in, ignite_rand, grow_rand     valid && ready
// out_if   out  cell_out, end_of_row, end_of_frame      valid && ready
// cfg      in   cfg_idx_i, cfg_wdata_i                  cfg_we_i
//
// One request per cycle sustained while the output does not stall; the
// line store's read-modify-write (with write-back forwarding) sets that figure.
// An emitting request passes the queue, stage one and the output register;
// its result is the cell C+1 raster positions earlier, C the column count.
// Reset clears counters, window, queue and output register; line stores are not
// cleared. Input ready drops only once an output stall has filled the queue.
module forest_fire_cell_stencil_unit #(
  parameter int MAX_COLS = ffcs_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = ffcs_pkg::MAX_ROWS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ffcs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ffcs_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  ffcs_in_if.sink                             in_if,
  ffcs_out_if.source                          out_if
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS + 2);
  localparam int QW = $bits(ffcs_pkg::item_t) + CW;
  localparam int LAST_COL_RST =
    ((ffcs_pkg::COLS_RESET > MAX_COLS) ? MAX_COLS : ffcs_pkg::COLS_RESET) - 1;
  localparam int LAST_ROW_RST =
    ((ffcs_pkg::ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ffcs_pkg::ROWS_RESET) - 1;

  ffcs_pkg::thr_t thr_q;
  logic [CW-1:0]  last_col_q, last_col_new;
  logic [RW-1:0]  last_row_q, last_row_new;

  logic [ffcs_pkg::ROWS_W-1:0] rows_raw;
  logic [ffcs_pkg::COLS_W-1:0] cols_raw;

  logic            push, full, q_valid, pop;
  ffcs_pkg::item_t fr_item, q_item;
  logic [CW-1:0]   fr_ic, q_ic;

  always_comb begin
    rows_raw = cfg_wdata_i[ffcs_pkg::ROWS_W-1:0];
    cols_raw = cfg_wdata_i[ffcs_pkg::COLS_W-1:0];
    if (rows_raw < ffcs_pkg::ROWS_W'(2)) begin
      last_row_new = RW'(1);
    end else if (32'(rows_raw) > MAX_ROWS) begin
      last_row_new = RW'(MAX_ROWS - 1);
    end else begin
      last_row_new = RW'(32'(rows_raw) - 1);
    end
    if (cols_raw < ffcs_pkg::COLS_W'(2)) begin
      last_col_new = CW'(1);
    end else if (32'(cols_raw) > MAX_COLS) begin
      last_col_new = CW'(MAX_COLS - 1);
    end else begin
      last_col_new = CW'(32'(cols_raw) - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= '0;
      last_col_q <= CW'(LAST_COL_RST);
      last_row_q <= RW'(LAST_ROW_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ffcs_pkg::CFG_IGN_THR:  thr_q.ign_thr  <= cfg_wdata_i;
        ffcs_pkg::CFG_GROW_THR: thr_q.grow_thr <= cfg_wdata_i;
        ffcs_pkg::CFG_ROWS:     last_row_q     <= last_row_new;
        ffcs_pkg::CFG_COLS:     last_col_q     <= last_col_new;
        default: begin
        end
      endcase
    end
  end

  ffcs_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .last_col_i (last_col_q),
    .last_row_i (last_row_q),
    .in_if      (in_if),
    .full_i     (full),
    .push_o     (push),
    .item_o     (fr_item),
    .ic_o       (fr_ic)
  );

  ffcs_queue #(
    .WIDTH (QW),
    .DEPTH (ffcs_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({fr_item, fr_ic}),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o ({q_item, q_ic})
  );

  ffcs_back #(
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .thr_i     (thr_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_ic_i    (q_ic),
    .pop_o     (pop),
    .out_if    (out_if)
  );

endmodule

@@ tb/sv/forest_fire_cell_stencil_unit_test.sv @@
module forest_fire_cell_stencil_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic            OP_CELL     = 1'b0;
  localparam logic            OP_FLUSH    = 1'b1;
  localparam ffcs_pkg::cell_t CELL_CODE3  = 2'd3;
  localparam int unsigned     CYCLE_LIMIT = 2_000_000;
  localparam int unsigned     MAX_SHOWN   = 10;

  typedef struct packed {
    logic                        op;
    ffcs_pkg::cell_t             kind;
    logic [ffcs_pkg::RAND_W-1:0] ign;
    logic [ffcs_pkg::RAND_W-1:0] grw;
  } fire_req_t;

  typedef struct packed {
    ffcs_pkg::cell_t next_kind;
    logic            eor;
    logic            eof;
  } next_cell_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [ffcs_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [ffcs_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  ffcs_in_if  req_if ();
  ffcs_out_if res_if ();

  forest_fire_cell_stencil_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (req_if),
    .out_if      (res_if)
  );

  // grid model state
  logic [ffcs_pkg::THR_W-1:0]  ign_thr  = '0;
  logic [ffcs_pkg::THR_W-1:0]  grow_thr = '0;
  logic [ffcs_pkg::ROWS_W-1:0] rows_reg = ffcs_pkg::ROWS_W'(ffcs_pkg::ROWS_RESET);
  logic [ffcs_pkg::COLS_W-1:0] cols_reg = ffcs_pkg::COLS_W'(ffcs_pkg::COLS_RESET);
  ffcs_pkg::cell_t upper_rows [ffcs_pkg::MAX_COLS_DEF] = '{default: ffcs_pkg::CELL_EMPTY};
  ffcs_pkg::cell_t middle_rows[ffcs_pkg::MAX_COLS_DEF] = '{default: ffcs_pkg::CELL_EMPTY};
  ffcs_pkg::cell_t window_q   [9]                      = '{default: ffcs_pkg::CELL_EMPTY};
  int unsigned     in_row  = 0;
  int unsigned     in_col  = 0;
  int unsigned     out_row = 0;
  int unsigned     out_col = 0;

  next_cell_t  expected_cells[$];
  int unsigned mismatch_count   = 0;
  int unsigned results_checked  = 0;
  int unsigned requests_sent    = 0;
  int unsigned frames_predicted = 0;
  int unsigned fires_predicted  = 0;
  int unsigned growths_predicted = 0;
  int unsigned input_stalls     = 0;
  int unsigned cycle_count      = 0;
  int unsigned hold_request     = 0;
  int unsigned burst_left       = 0;
  bit          gaps_on          = 1'b1;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic int unsigned grid_cols();
    if (cols_reg < 2) return 2;
    if (cols_reg > ffcs_pkg::MAX_COLS_DEF) return ffcs_pkg::MAX_COLS_DEF;
    return cols_reg;
  endfunction

  function automatic int unsigned grid_rows();
    if (rows_reg < 2) return 2;
    if (rows_reg > ffcs_pkg::MAX_ROWS_DEF) return ffcs_pkg::MAX_ROWS_DEF;
    return rows_reg;
  endfunction

  // advances the grid window by one request; returns 1 when a cell is emitted
  function automatic bit predict_next_cell(input fire_req_t r, output next_cell_t res);
    int unsigned     cols, rows, ic, trees, grow_lim, k, dc, dr;
    ffcs_pkg::cell_t cur, centre, v;
    bit              primed, has_top, has_bottom, has_left, has_right, burning_near;
    cols = grid_cols();
    rows = grid_rows();
    cur = (r.op == OP_FLUSH || r.kind == CELL_CODE3) ? ffcs_pkg::CELL_EMPTY : r.kind;
    ic = (in_col >= ffcs_pkg::MAX_COLS_DEF) ? ffcs_pkg::MAX_COLS_DEF - 1 : in_col;
    for (k = 0; k < 6; k++) window_q[k] = window_q[k + 3];
    window_q[6] = upper_rows[ic];
    window_q[7] = middle_rows[ic];
    window_q[8] = cur;
    upper_rows[ic] = middle_rows[ic];
    middle_rows[ic] = cur;
    primed = in_row >= 2 || (in_row == 1 && in_col >= 1);
    if (in_col >= cols - 1) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col++;
    end
    res = '0;
    if (!primed) return 1'b0;

    has_top    = out_row > 0;
    has_bottom = out_row < rows - 1;
    has_left   = out_col > 0;
    has_right  = out_col < cols - 1;
    trees = 0;
    burning_near = 1'b0;
    for (dc = 0; dc < 3; dc++) begin
      for (dr = 0; dr < 3; dr++) begin
        if (dc == 1 && dr == 1) continue;
        if ((dc == 0 && !has_left) || (dc == 2 && !has_right) ||
            (dr == 0 && !has_top) || (dr == 2 && !has_bottom)) continue;
        v = window_q[dc * 3 + dr];
        if (v == ffcs_pkg::CELL_TREE) trees++;
        if (v == ffcs_pkg::CELL_FIRE) burning_near = 1'b1;
      end
    end

    centre = window_q[4];
    grow_lim = grow_thr;
    grow_lim = grow_lim * (trees + 1);
    if (centre == ffcs_pkg::CELL_FIRE) begin
      res.next_kind = ffcs_pkg::CELL_EMPTY;
    end else if (centre == ffcs_pkg::CELL_TREE) begin
      res.next_kind = (burning_near || r.ign <= ign_thr) ? ffcs_pkg::CELL_FIRE
                                                         : ffcs_pkg::CELL_TREE;
      if (res.next_kind == ffcs_pkg::CELL_FIRE) fires_predicted++;
    end else begin
      res.next_kind = (r.grw <= grow_lim) ? ffcs_pkg::CELL_TREE : ffcs_pkg::CELL_EMPTY;
      if (res.next_kind == ffcs_pkg::CELL_TREE) growths_predicted++;
    end
    res.eor = out_col >= cols - 1;
    res.eof = res.eor && out_row >= rows - 1;

    if (res.eor) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
    if (res.eof) begin
      in_row = 0;
      in_col = 0;
      out_row = 0;
      out_col = 0;
      frames_predicted++;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin : check_results
    next_cell_t want;
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (expected_cells.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("unexpected result: cell=%0d eor=%0b eof=%0b",
                   res_if.cell_out, res_if.end_of_row, res_if.end_of_frame);
      end else begin
        want = expected_cells.pop_front();
        if (res_if.cell_out !== want.next_kind || res_if.end_of_row !== want.eor ||
            res_if.end_of_frame !== want.eof) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display({"mismatch at result %0d: expected cell=%0d eor=%0b eof=%0b,",
                      " got cell=%0d eor=%0b eof=%0b"},
                     results_checked, want.next_kind, want.eor, want.eof,
                     res_if.cell_out, res_if.end_of_row, res_if.end_of_frame);
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni && req_if.valid === 1'b1 && req_if.ready !== 1'b1) input_stalls++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_cells.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: rotating stall pattern that is re-drawn at random, plus long
  // hold-offs on request
  initial begin : drive_ready
    logic [15:0] stall_pattern;
    int unsigned hold_left, span;
    stall_pattern = 16'hFFFF;
    hold_left = 0;
    span = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (span == 0) begin
        span = $urandom_range(50, 300);
        stall_pattern = ($urandom_range(3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      end
      span--;
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= stall_pattern[0];
      end
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    end
  end

  task automatic send_request(input fire_req_t r);
    next_cell_t res;
    if (gaps_on && burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left != 0) burst_left--;
    req_if.valid       <= 1'b1;
    req_if.op          <= r.op;
    req_if.cell_in     <= r.kind;
    req_if.ignite_rand <= r.ign;
    req_if.grow_rand   <= r.grw;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    requests_sent++;
    if (predict_next_cell(r, res)) expected_cells.push_back(res);
  endtask

  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic load_rules(input logic [ffcs_pkg::THR_W-1:0] ign,
                            input logic [ffcs_pkg::THR_W-1:0] grow,
                            input logic [ffcs_pkg::ROWS_W-1:0] rows,
                            input logic [ffcs_pkg::COLS_W-1:0] cols);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= ffcs_pkg::CFG_IGN_THR;
    cfg_wdata_i <= ffcs_pkg::CFG_DATA_W'(ign);
    @(posedge clk_i);
    cfg_idx_i   <= ffcs_pkg::CFG_GROW_THR;
    cfg_wdata_i <= ffcs_pkg::CFG_DATA_W'(grow);
    @(posedge clk_i);
    cfg_idx_i   <= ffcs_pkg::CFG_ROWS;
    cfg_wdata_i <= ffcs_pkg::CFG_DATA_W'(rows);
    @(posedge clk_i);
    cfg_idx_i   <= ffcs_pkg::CFG_COLS;
    cfg_wdata_i <= ffcs_pkg::CFG_DATA_W'(cols);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    ign_thr  = ign;
    grow_thr = grow;
    rows_reg = rows;
    cols_reg = cols;
  endtask

  function automatic fire_req_t make_req(input logic op, input ffcs_pkg::cell_t kind,
                                         input logic [ffcs_pkg::RAND_W-1:0] ign,
                                         input logic [ffcs_pkg::RAND_W-1:0] grw);
    fire_req_t r;
    r.op   = op;
    r.kind = kind;
    r.ign  = ign;
    r.grw  = grw;
    return r;
  endfunction

  function automatic logic [ffcs_pkg::RAND_W-1:0] random_fraction();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return ffcs_pkg::RAND_W'($urandom);
    endcase
  endfunction

  function automatic ffcs_pkg::cell_t random_kind();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 4) return ffcs_pkg::CELL_EMPTY;
    if (pick < 8) return ffcs_pkg::CELL_TREE;
    if (pick == 8) return ffcs_pkg::CELL_FIRE;
    return CELL_CODE3;
  endfunction

  // one frame of cells followed by the flush tail; noise swaps cell and flush
  task automatic run_frame(input int unsigned noise_pct);
    int unsigned rows, cols, i;
    fire_req_t   r;
    rows = grid_rows();
    cols = grid_cols();
    for (i = 0; i < rows * cols + cols + 1; i++) begin
      r.op = (i < rows * cols) ? OP_CELL : OP_FLUSH;
      if ($urandom_range(99) < noise_pct) r.op = ~r.op;
      r.kind = random_kind();
      r.ign  = random_fraction();
      r.grw  = random_fraction();
      send_request(r);
    end
  endtask

  task automatic test_directed();
    // 2x2 via clamped sizes: flush inside frame, code three, cell in flush slot
    load_rules('0, '0, 12'd1, 8'd0);
    send_request(make_req(OP_CELL,  ffcs_pkg::CELL_FIRE,  16'h0000, 16'h0000));
    send_request(make_req(OP_CELL,  ffcs_pkg::CELL_TREE,  16'hFFFF, 16'hFFFF));
    send_request(make_req(OP_FLUSH, ffcs_pkg::CELL_TREE,  16'h0000, 16'h0000));
    send_request(make_req(OP_CELL,  CELL_CODE3,           16'hFFFF, 16'h0000));
    send_request(make_req(OP_FLUSH, ffcs_pkg::CELL_FIRE,  16'h0000, 16'hFFFF));
    send_request(make_req(OP_CELL,  ffcs_pkg::CELL_TREE,  16'hFFFF, 16'h0001));
    send_request(make_req(OP_FLUSH, CELL_CODE3,           16'h0001, 16'h0000));
    wait_results_drained();
    // 3x3: spread of fire, lightning at and just above threshold, growth
    load_rules(16'h0100, 16'h2000, 12'd3, 8'd3);
    send_request(make_req(OP_CELL,  ffcs_pkg::CELL_FIRE,  16'h0101, 16'hFFFF));
    send_request(make_req(OP_CELL,  ffcs_pkg::CELL_TREE,  16'h0101, 16'h2001));
    send_request(make_req(OP_CELL,  ffcs_pkg::CELL_EMPTY, 16'h0100, 16'h4000));
    send_request(make_req(OP_CELL,  ffcs_pkg::CELL_EMPTY, 16'h0101, 16'h6000));
    send_request(make_req(OP_CELL,  ffcs_pkg::CELL_EMPTY, 16'h0101, 16'h4001));
    send_request(make_req(OP_CELL,  ffcs_pkg::CELL_TREE,  16'h0100, 16'h2000));
    send_request(make_req(OP_CELL,  ffcs_pkg::CELL_TREE,  16'h0101, 16'h0000));
    send_request(make_req(OP_CELL,  ffcs_pkg::CELL_EMPTY, 16'h0000, 16'h4000));
    send_request(make_req(OP_CELL,  ffcs_pkg::CELL_EMPTY, 16'hFFFF, 16'h8000));
    send_request(make_req(OP_FLUSH, ffcs_pkg::CELL_EMPTY, 16'h00FF, 16'h2000));
    send_request(make_req(OP_FLUSH, ffcs_pkg::CELL_EMPTY, 16'h0101, 16'h2001));
    send_request(make_req(OP_FLUSH, ffcs_pkg::CELL_EMPTY, 16'h0100, 16'h1FFF));
    send_request(make_req(OP_FLUSH, ffcs_pkg::CELL_EMPTY, 16'h0101, 16'h4001));
  endtask

  task automatic test_register_extremes();
    wait_results_drained();
    load_rules('0, '0, 12'd2, 8'd255);
    run_frame(0);
    wait_results_drained();
    load_rules('1, '1, 12'd3, 8'd7);
    run_frame(0);
    wait_results_drained();
    load_rules(16'h4000, 16'h1000, 12'd0, 8'd1);
    run_frame(10);
    wait_results_drained();
    load_rules(16'h8000, 16'h1C71, 12'd9, 8'd2);
    run_frame(0);
  endtask

  task automatic test_output_backpressure();
    wait_results_drained();
    load_rules(ffcs_pkg::RAND_W'($urandom), ffcs_pkg::RAND_W'($urandom), 12'd6, 8'd12);
    gaps_on = 1'b0;
    hold_request = 120;
    run_frame(0);
    run_frame(0);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int unsigned                 start_count;
    logic [ffcs_pkg::ROWS_W-1:0] rows;
    logic [ffcs_pkg::COLS_W-1:0] cols;
    start_count = requests_sent;
    while (requests_sent - start_count < 550) begin
      if ($urandom_range(2) != 0) begin
        wait_results_drained();
        rows = ffcs_pkg::ROWS_W'($urandom_range(2, 8));
        cols = ffcs_pkg::COLS_W'($urandom_range(2, 12));
        if ($urandom_range(9) == 0) begin
          rows = ffcs_pkg::ROWS_W'($urandom_range(0, 3));
          cols = ffcs_pkg::COLS_W'($urandom_range(100, 255));
        end else if ($urandom_range(9) == 0) begin
          rows = ffcs_pkg::ROWS_W'($urandom_range(0, 1));
          cols = ffcs_pkg::COLS_W'($urandom_range(0, 1));
        end
        load_rules(random_fraction(), random_fraction(), rows, cols);
      end
      gaps_on = $urandom_range(9) < 7;
      run_frame(($urandom_range(4) == 0) ? 8 : 0);
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= ffcs_pkg::CFG_IGN_THR;
    cfg_wdata_i        <= '0;
    req_if.valid       <= 1'b0;
    req_if.op          <= OP_CELL;
    req_if.cell_in     <= ffcs_pkg::CELL_EMPTY;
    req_if.ignite_rand <= '0;
    req_if.grow_rand   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_register_extremes();
    test_output_backpressure();
    test_random_frames();

    wait_results_drained();
    repeat (10) @(posedge clk_i);

    $display("Ran %0d requests over %0d frames: clamped sizes, code-three cells, %s",
             requests_sent, frames_predicted, "misplaced flushes");
    $display("Checked %0d cells (%0d ignitions, %0d growths), input stalled %0d cycles",
             results_checked, fires_predicted, growths_predicted, input_stalls);
    if (mismatch_count == 0 && expected_cells.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/ffcs_pkg.sv
design/ffcs_if.sv
design/ffcs_front.sv
design/ffcs_queue.sv
design/ffcs_back.sv
design/forest_fire_cell_stencil_unit.sv
tb/sv/forest_fire_cell_stencil_unit_test.sv
